@@ rtl/rsrp_pkg.sv @@
package rsrp_pkg;

  localparam int SRC_WIDTH  = 256;
  localparam int SRC_HEIGHT = 384;
  localparam int MAX_SCALE  = 3;
  localparam int HALF_H     = SRC_HEIGHT / 2;

  localparam int PIX_W      = 16;
  localparam int SCOL_W     = 8;
  localparam int SROW_W     = 9;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 11;
  localparam int IDX_W      = 20;
  localparam int CH_W       = 8;
  localparam int SCALE_W    = 2;
  localparam int ROWW_W     = $clog2(SRC_WIDTH * MAX_SCALE + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_color;
    logic [SCOL_W-1:0] src_col;
    logic [SROW_W-1:0] src_row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [IDX_W-1:0] out_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last_write;
  } out_t;

  // One classified pixel: top-left corner of its scaled block and its colour.
  typedef struct packed {
    logic [ROW_W-1:0]   r0;
    logic [COL_W-1:0]   c0;
    logic [IDX_W-1:0]   idx0;
    logic [ROWW_W-1:0]  row_w;
    logic [SCALE_W-1:0] s;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
  } entry_t;

  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] sc);
    logic [SCALE_W-1:0] s;
    s = sc;
    if (s == '0) s = SCALE_W'(1);
    if (32'(s) > MAX_SCALE) s = SCALE_W'(MAX_SCALE);
    return s;
  endfunction

endpackage

@@ rtl/rsrp_front.sv @@
module rsrp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  rsrp_pkg::in_t   in_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [rsrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsrp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic            q_push,
  output rsrp_pkg::entry_t q_wr,
  input  logic            q_full
);
  import rsrp_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic               rotate_r;

  logic               s1_v_r;
  logic [ROW_W-1:0]   s1_r0_r;
  logic [COL_W-1:0]   s1_c0_r;
  logic [ROWW_W-1:0]  s1_roww_r;
  logic [SCALE_W-1:0] s1_s_r;
  logic [CH_W-1:0]    s1_red_r, s1_green_r, s1_blue_r;

  logic               s2_v_r;
  entry_t             s2_r;

  logic               s1_ready, s2_ready, accept, in_frame, half;
  logic [SCALE_W-1:0] s;
  logic [ROW_W-1:0]   base_row;
  logic [COL_W-1:0]   base_col;
  logic [ROWW_W-1:0]  roww;

  assign cfg_ready = 1'b1;

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign full     = !s1_ready;
  assign accept   = push && s1_ready;
  assign q_push   = s2_v_r && !q_full;
  assign q_wr     = s2_r;

  always_comb begin
    s        = eff_scale(scale_r);
    in_frame = (32'(in_data.src_col) < SRC_WIDTH) && (32'(in_data.src_row) < SRC_HEIGHT);
    half     = 32'(in_data.src_row) >= HALF_H;
    if (rotate_r) begin
      base_row = ROW_W'(SRC_WIDTH - 1) - ROW_W'(in_data.src_col);
      if (half) base_row = base_row + ROW_W'(SRC_WIDTH);
      base_col = COL_W'(in_data.src_row);
      if (half) base_col = base_col - COL_W'(HALF_H);
      roww     = ROWW_W'(ROWW_W'(HALF_H) * ROWW_W'(s));
    end else begin
      base_row = ROW_W'(in_data.src_row);
      base_col = COL_W'(in_data.src_col);
      roww     = ROWW_W'(ROWW_W'(SRC_WIDTH) * ROWW_W'(s));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(1);
      rotate_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
          CFG_ROTATE: rotate_r <= cfg_data[0];
          default: ;
        endcase
      end
      // drop out-of-frame pixels at the door
      if (s1_ready) s1_v_r <= accept && in_frame;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r0_r    <= ROW_W'(base_row * ROW_W'(s));
      s1_c0_r    <= COL_W'(base_col * COL_W'(s));
      s1_roww_r  <= roww;
      s1_s_r     <= s;
      s1_red_r   <= {in_data.pixel_color[4:0], 3'b000};
      s1_green_r <= {in_data.pixel_color[9:5], 3'b000};
      s1_blue_r  <= {in_data.pixel_color[14:10], 3'b000};
    end
    if (s2_ready) begin
      s2_r.r0    <= s1_r0_r;
      s2_r.c0    <= s1_c0_r;
      s2_r.idx0  <= IDX_W'(IDX_W'(s1_r0_r) * IDX_W'(s1_roww_r)) + IDX_W'(s1_c0_r);
      s2_r.row_w <= s1_roww_r;
      s2_r.s     <= s1_s_r;
      s2_r.red   <= s1_red_r;
      s2_r.green <= s1_green_r;
      s2_r.blue  <= s1_blue_r;
    end
  end

endmodule

@@ rtl/rsrp_queue.sv @@
module rsrp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  rsrp_pkg::entry_t q_wr,
  output logic             q_full,
  input  logic             q_pop,
  output rsrp_pkg::entry_t q_rd,
  output logic             q_empty
);
  import rsrp_pkg::*;

  entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign q_full  = 32'(cnt_r) == Q_DEPTH;
  assign q_empty = cnt_r == '0;
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + Q_CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr;
  end

endmodule

@@ rtl/rsrp_back.sv @@
module rsrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rsrp_pkg::entry_t q_rd,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output rsrp_pkg::out_t   out_data
);
  import rsrp_pkg::*;

  entry_t             cur_r;
  logic               cur_v_r;
  logic [SCALE_W-1:0] dx_r, dy_r;
  logic [IDX_W-1:0]   row_idx_r;
  out_t               out_r;
  logic               out_v_r;

  logic               produce, last, end_row;

  assign end_row  = dx_r == cur_r.s - SCALE_W'(1);
  assign last     = end_row && (dy_r == cur_r.s - SCALE_W'(1));
  assign produce  = cur_v_r && (!out_v_r || pop);
  assign q_pop    = !q_empty && (!cur_v_r || (produce && last));
  assign empty    = !out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) cur_v_r <= 1'b1;
      else if (produce && last) cur_v_r <= 1'b0;
      if (produce) out_v_r <= 1'b1;
      else if (pop) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_r.out_col    <= cur_r.c0 + COL_W'(dx_r);
      out_r.out_row    <= cur_r.r0 + ROW_W'(dy_r);
      out_r.out_index  <= row_idx_r + IDX_W'(dx_r);
      out_r.red        <= cur_r.red;
      out_r.green      <= cur_r.green;
      out_r.blue       <= cur_r.blue;
      out_r.last_write <= last;
    end
    // load the next pixel as the last write of this one goes out
    if (q_pop) begin
      cur_r     <= q_rd;
      dx_r      <= '0;
      dy_r      <= '0;
      row_idx_r <= q_rd.idx0;
    end else if (produce) begin
      if (end_row) begin
        dx_r      <= '0;
        dy_r      <= dy_r + SCALE_W'(1);
        row_idx_r <= row_idx_r + IDX_W'(cur_r.row_w);
      end else begin
        dx_r <= dx_r + SCALE_W'(1);
      end
    end
  end

endmodule

@@ rtl/rgb555_scale_rotate_placer.sv @@
// Scaled pixel placer for a two-screen RGB555 frame.
// Input queue side: present a pixel with its column and row on in_data and raise
// push; the item is taken on a clock edge where full is low.  Pixels outside the
// frame are taken and dropped without any write.
// Result queue side: while empty is low, out_data holds the oldest pending write
// (position, linear index, 8-bit colour, last_write on the final one of a pixel);
// raise pop to take it.
// Configuration: cfg_index 0 sets scale, 1 sets rotate; cfg_ready is always high.
// Write only while no pixel is in flight.
// Each pixel yields scale*scale writes, one per cycle from the back-end counter
// while pop keeps up, and input sustains that rate.  The first write of a pixel
// passes through two front stages (mapping, then the index multiply), the
// four-entry queue, the back-end pixel register and the output register.
// When pop stays low the output register holds, the back end stops, the queue
// fills and full rises; nothing is lost.  Reset sets scale 1, rotate 0 and
// empties every stage.
module rgb555_scale_rotate_placer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  rsrp_pkg::in_t                   in_data,
  output logic                            empty,
  input  logic                            pop,
  output rsrp_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsrp_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr, q_rd;

  rsrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_wr      (q_wr),
    .q_full    (q_full)
  );

  rsrp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rd    (q_rd),
    .q_empty (q_empty)
  );

  rsrp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

@@ sim/rgb555_scale_rotate_placer_test.sv @@
`timescale 1ns / 1ps

module rgb555_scale_rotate_placer_test;
  import rsrp_pkg::*;

  localparam int ITEM_TARGET   = 460;
  localparam int RAND_PHASES   = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 160;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_t                   in_data   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rgb555_scale_rotate_placer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  in_t                pixel_queue[$];
  out_t               pending_writes[$];
  logic [SCALE_W-1:0] scale_reg  = SCALE_W'(1);
  logic               rotate_reg = 1'b0;
  bit                 pixel_taken;
  int                 mismatch_cnt;
  int                 idle_cycles;
  int                 send_gap;
  int                 recv_hold;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 long_hold_req;
  int                 long_hold_seen;

  // Expand the colour and lay out the scaled block of writes for one pixel.
  function automatic void place_pixel(input in_t px);
    int unsigned s, half, base_r, base_c, row_w, r, c;
    out_t w;
    if (px.src_col >= SRC_WIDTH || px.src_row >= SRC_HEIGHT) return;
    s = (scale_reg == '0) ? 1 : scale_reg;
    if (s > MAX_SCALE) s = MAX_SCALE;
    if (rotate_reg) begin
      half   = (px.src_row >= HALF_H) ? 1 : 0;
      base_r = half * SRC_WIDTH + SRC_WIDTH - 1 - px.src_col;
      base_c = px.src_row - half * HALF_H;
      row_w  = HALF_H * s;
    end else begin
      base_r = px.src_row;
      base_c = px.src_col;
      row_w  = SRC_WIDTH * s;
    end
    for (int unsigned dy = 0; dy < s; dy++) begin
      for (int unsigned dx = 0; dx < s; dx++) begin
        r = base_r * s + dy;
        c = base_c * s + dx;
        w.out_col    = COL_W'(c);
        w.out_row    = ROW_W'(r);
        w.out_index  = IDX_W'(r * row_w + c);
        w.red        = {px.pixel_color[4:0], 3'b000};
        w.green      = {px.pixel_color[9:5], 3'b000};
        w.blue       = {px.pixel_color[14:10], 3'b000};
        w.last_write = (dy == s - 1) && (dx == s - 1);
        pending_writes.push_back(w);
      end
    end
  endfunction

  function automatic void flag_write(input string what, input out_t exp_w, input out_t got_w);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t %s: col %0d/%0d row %0d/%0d index %0d/%0d", $realtime, what,
               exp_w.out_col, got_w.out_col, exp_w.out_row, got_w.out_row,
               exp_w.out_index, got_w.out_index);
    if (mismatch_cnt <= REPORT_MAX)
      $display("  rgb %h %h %h / %h %h %h last %0b/%0b (expected/actual)",
               exp_w.red, exp_w.green, exp_w.blue, got_w.red, got_w.green, got_w.blue,
               exp_w.last_write, got_w.last_write);
  endfunction

  function automatic void queue_pixel(input logic [PIX_W-1:0] pix, input int col, input int row);
    in_t px;
    px.pixel_color = pix;
    px.src_col     = SCOL_W'(col);
    px.src_row     = SROW_W'(row);
    pixel_queue.push_back(px);
  endfunction

  // Read at the falling edge: every item accepted and every write drained.
  function automatic bit all_done();
    return pixel_queue.size() == 0 && (!push || pixel_taken) && pending_writes.size() == 0;
  endfunction

  task automatic settle();
    while (!all_done()) @(negedge clk);
    // out-of-frame items leave no write behind but may still be in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: hold an offered item until it is taken, then advance or idle.
  always @(negedge clk) begin
    if (rst_n && !(push && !pixel_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        push <= 1'b0;
      end else if ($urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 10);
        push <= 1'b0;
      end else begin
        in_data <= pixel_queue.pop_front();
        push    <= 1'b1;
      end
    end
  end

  // Receiver: random short holds, plus one long hold on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_hold > 0) begin
        recv_hold--;
        pop <= 1'b0;
      end else if (long_hold_seen != long_hold_req) begin
        long_hold_seen = long_hold_req;
        recv_hold = LONG_HOLD - 1;
        pop <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_hold = $urandom_range(0, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      pixel_taken = push && !full;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCALE) scale_reg = cfg_data[SCALE_W-1:0];
        else if (cfg_index == CFG_ROTATE) rotate_reg = cfg_data[0];
      end
      if (pixel_taken) place_pixel(in_data);
      if (pop && !empty) begin
        if (pending_writes.size() == 0) flag_write("unexpected write", '0, out_data);
        else if (out_data !== pending_writes[0]) begin
          flag_write("write mismatch", pending_writes[0], out_data);
          void'(pending_writes.pop_front());
        end else void'(pending_writes.pop_front());
      end
      if (pixel_taken || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int                 in_frame;
    in_t                px;
    logic [SCALE_W-1:0] sc;
    logic               rot;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 15;

    // reset settings: scale one, no rotation; colour extremes and bit 15 alone
    queue_pixel(16'h0000, 0, 0);
    queue_pixel(16'hFFFF, 255, 383);
    queue_pixel(16'h7FFF, 255, 191);
    queue_pixel(16'h8000, 128, 192);
    queue_pixel(16'h001F, 1, 1);
    queue_pixel(16'h03E0, 2, 2);
    queue_pixel(16'h7C00, 3, 3);
    // rows past the frame are dropped
    queue_pixel(16'h5555, 10, 384);
    queue_pixel(16'hAAAA, 255, 511);
    settle();

    // surplus data bits ignored: scale three, rotated
    write_reg(CFG_SCALE, 8'hFF);
    write_reg(CFG_ROTATE, 8'h01);
    queue_pixel(16'h5555, 0, 0);
    queue_pixel(16'hAAAA, 255, 191);
    queue_pixel(16'h7FFF, 0, 192);
    queue_pixel(16'hFFFF, 255, 383);
    queue_pixel(16'h1234, 0, 383);
    settle();

    // zero scale acts as one
    write_reg(CFG_SCALE, 8'h00);
    write_reg(CFG_ROTATE, 8'hFE);
    queue_pixel(16'h4321, 255, 0);
    queue_pixel(16'hBEEF, 7, 300);
    settle();

    write_reg(CFG_SCALE, 8'h02);
    write_reg(CFG_SPARE_A, 8'h03);
    write_reg(CFG_SPARE_B, 8'hFF);
    write_reg(CFG_ROTATE, 8'h01);
    queue_pixel(16'hF00F, 17, 191);
    queue_pixel(16'h0FF0, 200, 192);
    queue_pixel(16'hFFFF, 255, 383);

    in_frame = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        sc  = SCALE_W'(3);
        rot = 1'b1;
      end else if (ph == 1) begin
        sc  = SCALE_W'(1);
        rot = 1'b0;
      end else begin
        sc  = SCALE_W'($urandom_range(0, 3));
        rot = 1'($urandom_range(0, 1));
      end
      write_reg(CFG_SCALE, {6'($urandom), sc});
      write_reg(CFG_ROTATE, {7'($urandom), rot});
      // some phases run without idling; the last one runs flat out
      send_idle_pct = (ph % 3 == 2 || ph == RAND_PHASES - 1) ? 0 : 20;
      recv_idle_pct = (ph % 4 == 3 || ph == RAND_PHASES - 1) ? 0 : 20;
      while (in_frame < (ph + 1) * ITEM_TARGET / RAND_PHASES) begin
        px.pixel_color = PIX_W'($urandom);
        if ($urandom_range(0, 7) == 0) px.src_col = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else px.src_col = SCOL_W'($urandom);
        if ($urandom_range(0, 15) == 0) begin
          px.src_row = SROW_W'($urandom_range(SRC_HEIGHT, 2 ** SROW_W - 1));
          pixel_queue.push_back(px);
        end else begin
          px.src_row = SROW_W'($urandom_range(0, SRC_HEIGHT - 1));
          pixel_queue.push_back(px);
          in_frame++;
          // starve the output so the block fills and pushes back
          if (ph == 0 && in_frame == 20) long_hold_req++;
          // pause the input until every write has drained
          if (ph == 4 && in_frame % (ITEM_TARGET / RAND_PHASES) == 20)
            while (!all_done()) @(negedge clk);
        end
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ rgb555_scale_rotate_placer.f @@
rtl/rsrp_pkg.sv
rtl/rsrp_front.sv
rtl/rsrp_queue.sv
rtl/rsrp_back.sv
rtl/rgb555_scale_rotate_placer.sv
sim/rgb555_scale_rotate_placer_test.sv
